### src/gimb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gimb_pkg
// Shared types, constants and helpers for the gimbal rotation matrix core.
// ---------------------------------------------------------------------------
package gimb_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 16;
    localparam int COEF_FRAC_BITS_DEF  = 30;
    localparam int CORDIC_STAGES_DEF   = 24;

    localparam int WORK_FRAC = 30;
    localparam int WW        = 34;   // working coefficient width
    localparam int XW        = 43;   // CORDIC x/y width, 40 fraction bits
    localparam int ZW        = 34;   // CORDIC residual width
    localparam int NLANE     = 5;

    localparam logic [63:0] TURN_PER_RAD = 64'h0A2F9836E4E44153;
    localparam logic [63:0] TURN_PER_DEG = 64'd12810238940076078;
    localparam logic signed [XW-1:0] GAIN_Q40 = 43'sd667681663043;
    localparam logic signed [WW-1:0] ONE = 34'sd1073741824;

    typedef logic signed [WW-1:0] t_w;
    typedef t_w [2:0][2:0] t_mat;

    typedef struct packed {
        logic signed [WW-1:0] c;
        logic signed [WW-1:0] s;
    } t_trig;

    typedef t_trig [NLANE-1:0] t_trig_vec;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic [1:0]           q;
    } t_crd;

    typedef struct packed {
        logic signed [31:0] yaw_angle;
        logic signed [31:0] pitch_angle;
        logic signed [31:0] roll_angle;
        logic signed [31:0] depression_angle;
        logic signed [31:0] azimuth_angle;
    } t_in;

    typedef struct packed {
        logic signed [31:0] m00;
        logic signed [31:0] m01;
        logic signed [31:0] m02;
        logic signed [31:0] m10;
        logic signed [31:0] m11;
        logic signed [31:0] m12;
        logic signed [31:0] m20;
        logic signed [31:0] m21;
        logic signed [31:0] m22;
    } t_out;

    function automatic logic [29:0] atan_val(input int idx);
        logic [29:0] v;
        case (idx)
            0: v = 30'd536870912;  1: v = 30'd316933406;  2: v = 30'd167458907;
            3: v = 30'd85004756;   4: v = 30'd42667331;   5: v = 30'd21354465;
            6: v = 30'd10679838;   7: v = 30'd5340245;    8: v = 30'd2670163;
            9: v = 30'd1335087;   10: v = 30'd667544;    11: v = 30'd333772;
            12: v = 30'd166886;   13: v = 30'd83443;     14: v = 30'd41722;
            15: v = 30'd20861;    16: v = 30'd10430;     17: v = 30'd5215;
            18: v = 30'd2608;     19: v = 30'd1304;      20: v = 30'd652;
            21: v = 30'd326;      22: v = 30'd163;       23: v = 30'd81;
            24: v = 30'd41;       25: v = 30'd20;        26: v = 30'd10;
            27: v = 30'd5;        28: v = 30'd3;         29: v = 30'd1;
            30: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    function automatic t_mat rot_x(input t_trig t);
        t_mat m;
        m[0][0] = ONE; m[0][1] = '0;   m[0][2] = '0;
        m[1][0] = '0;  m[1][1] = t.c;  m[1][2] = t.s;
        m[2][0] = '0;  m[2][1] = -t.s; m[2][2] = t.c;
        return m;
    endfunction

    function automatic t_mat rot_y(input t_trig t);
        t_mat m;
        m[0][0] = t.c; m[0][1] = '0;   m[0][2] = -t.s;
        m[1][0] = '0;  m[1][1] = ONE;  m[1][2] = '0;
        m[2][0] = t.s; m[2][1] = '0;   m[2][2] = t.c;
        return m;
    endfunction

    function automatic t_mat rot_z(input t_trig t);
        t_mat m;
        m[0][0] = t.c;  m[0][1] = t.s; m[0][2] = '0;
        m[1][0] = -t.s; m[1][1] = t.c; m[1][2] = '0;
        m[2][0] = '0;   m[2][1] = '0;  m[2][2] = ONE;
        return m;
    endfunction

endpackage
`default_nettype wire

### src/gimbal_euler_to_rotation_matrix_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gimbal_euler_to_rotation_matrix_core
// Five attitude angles to the 3x3 rotation matrix Ry*Rx*Rx*Ry*Rz.
//
// Channel   Signals                     Transaction
// input     start, busy, i_in           start high, busy low
// output    o_valid, o_out              o_valid high for one cycle
// config    i_cfg_we, i_cfg_wdata       i_cfg_we high
//
// One transaction per cycle; busy is always low.
// Data passes in order through the phase multiply, the CORDIC cell
// chain, the quadrant map, four matrix products and output rounding,
// all registered. Reset clears only the unit register and valid line.
// ---------------------------------------------------------------------------
module gimbal_euler_to_rotation_matrix_core #(
    parameter int ANGLE_FRAC_BITS = gimb_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int COEF_FRAC_BITS  = gimb_pkg::COEF_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES   = gimb_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire gimb_pkg::t_in i_in,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_wdata,
    output logic               o_valid,
    output gimb_pkg::t_out     o_out
);
    localparam int LAT  = CORDIC_STAGES + 12;
    localparam int DROP = gimb_pkg::WORK_FRAC - COEF_FRAC_BITS;
    localparam logic signed [34:0] LIM = 35'sd1 <<< COEF_FRAC_BITS;

    logic r_angle_unit;
    logic [LAT-1:0] r_vld;
    logic [31:0] w_angle [gimb_pkg::NLANE];
    logic [31:0] w_phase [gimb_pkg::NLANE];
    gimb_pkg::t_crd w_crd [gimb_pkg::NLANE][CORDIC_STAGES+1];
    gimb_pkg::t_trig_vec r_trig;
    gimb_pkg::t_mat w_acc [5];
    gimb_pkg::t_trig_vec w_tv [5];
    gimb_pkg::t_mat w_b [4];
    gimb_pkg::t_out r_out;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_unit <= 1'b0;
            r_vld        <= '0;
        end else begin
            if (i_cfg_we) begin
                r_angle_unit <= i_cfg_wdata;
            end
            r_vld <= {r_vld[LAT-2:0], start && !busy};
        end
    end

    assign w_angle[0] = i_in.yaw_angle;
    assign w_angle[1] = i_in.pitch_angle;
    assign w_angle[2] = i_in.roll_angle;
    assign w_angle[3] = i_in.depression_angle;
    assign w_angle[4] = i_in.azimuth_angle;

    for (genvar l = 0; l < gimb_pkg::NLANE; l++) begin : g_lane
        localparam int XQ = 2;
        logic [31:0] w_qs, w_d;
        logic [XQ-1:0] w_q;
        logic signed [gimb_pkg::WW-1:0] w_c, w_s;
        logic signed [gimb_pkg::XW-1:0] w_xr, w_yr;

        gimb_phase #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_phase (
            .i_clk   (i_clk),
            .i_unit  (r_angle_unit),
            .i_angle (w_angle[l]),
            .o_phase (w_phase[l])
        );

        assign w_qs = w_phase[l] + 32'h2000_0000;
        assign w_q  = w_qs[31:30];
        assign w_d  = w_phase[l] - {w_q, 30'd0};
        assign w_crd[l][0] = '{x: gimb_pkg::GAIN_Q40, y: '0,
                               z: $signed({{(gimb_pkg::ZW-32){w_d[31]}}, w_d}), q: w_q};

        for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
            gimb_cordic_cell #(.IDX(k)) u_cell (
                .i_clk (i_clk),
                .i_d   (w_crd[l][k]),
                .o_d   (w_crd[l][k+1])
            );
        end

        assign w_xr = (w_crd[l][CORDIC_STAGES].x + 43'sd512) >>> 10;
        assign w_yr = (w_crd[l][CORDIC_STAGES].y + 43'sd512) >>> 10;
        assign w_c  = w_xr[gimb_pkg::WW-1:0];
        assign w_s  = w_yr[gimb_pkg::WW-1:0];

        always_ff @(posedge i_clk) begin
            case (w_crd[l][CORDIC_STAGES].q)
                2'd0:    begin r_trig[l].c <= w_c;  r_trig[l].s <= w_s;  end
                2'd1:    begin r_trig[l].c <= -w_s; r_trig[l].s <= w_c;  end
                2'd2:    begin r_trig[l].c <= -w_c; r_trig[l].s <= -w_s; end
                default: begin r_trig[l].c <= w_s;  r_trig[l].s <= -w_c; end
            endcase
        end
    end

    assign w_acc[0] = gimb_pkg::rot_y(r_trig[4]);
    assign w_tv[0]  = r_trig;
    assign w_b[0]   = gimb_pkg::rot_x(w_tv[0][3]);
    assign w_b[1]   = gimb_pkg::rot_x(w_tv[1][2]);
    assign w_b[2]   = gimb_pkg::rot_y(w_tv[2][1]);
    assign w_b[3]   = gimb_pkg::rot_z(w_tv[3][0]);

    for (genvar m = 0; m < 4; m++) begin : g_mul
        gimb_matmul u_mul (
            .i_clk  (i_clk),
            .i_a    (w_acc[m]),
            .i_b    (w_b[m]),
            .i_trig (w_tv[m]),
            .o_m    (w_acc[m+1]),
            .o_trig (w_tv[m+1])
        );
    end

    logic [31:0] w_ent [9];
    for (genvar e = 0; e < 9; e++) begin : g_ent
        logic signed [34:0] w_v, w_r;
        assign w_v = 35'($signed(w_acc[4][e/3][e%3]));
        if (DROP > 0) begin : g_rnd
            assign w_r = (w_v + (35'sd1 <<< (DROP-1))) >>> DROP;
        end else begin : g_nornd
            assign w_r = w_v;
        end
        always_comb begin
            if (w_r > LIM) begin
                w_ent[e] = LIM[31:0];
            end else if (w_r < -LIM) begin
                w_ent[e] = 32'(-LIM);
            end else begin
                w_ent[e] = w_r[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= '{m00: w_ent[0], m01: w_ent[1], m02: w_ent[2],
                   m10: w_ent[3], m11: w_ent[4], m12: w_ent[5],
                   m20: w_ent[6], m21: w_ent[7], m22: w_ent[8]};
    end

    assign o_out   = r_out;
    assign o_valid = r_vld[LAT-1];
endmodule
`default_nettype wire

### src/gimb_phase.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gimb_phase
// Converts a fixed point angle to a 32-bit phase, two register stages.
// ---------------------------------------------------------------------------
module gimb_phase #(
    parameter int ANGLE_FRAC_BITS = gimb_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_unit,
    input  wire logic signed [31:0] i_angle,
    output logic [31:0]             o_phase
);
    logic [63:0] w_c;
    logic signed [64:0] w_plo, w_phi;
    logic signed [63:0] r_plo, r_phi;
    logic [63:0] w_mid;

    assign w_c   = i_unit ? gimb_pkg::TURN_PER_DEG : gimb_pkg::TURN_PER_RAD;
    assign w_plo = i_angle * $signed({1'b0, w_c[31:0]});
    assign w_phi = i_angle * $signed({1'b0, w_c[63:32]});

    always_ff @(posedge i_clk) begin
        r_plo <= w_plo[63:0];
        r_phi <= w_phi[63:0];
    end

    assign w_mid = r_phi + {{32{r_plo[63]}}, r_plo[63:32]};

    always_ff @(posedge i_clk) begin
        o_phase <= w_mid[ANGLE_FRAC_BITS-2 +: 32];
    end
endmodule
`default_nettype wire

### src/gimb_cordic_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gimb_cordic_cell
// One rotation-mode CORDIC iteration, registered.
// ---------------------------------------------------------------------------
module gimb_cordic_cell #(
    parameter int IDX = 0
) (
    input  wire logic            i_clk,
    input  wire gimb_pkg::t_crd  i_d,
    output gimb_pkg::t_crd       o_d
);
    localparam logic signed [gimb_pkg::ZW-1:0] ATAN =
        $signed({{(gimb_pkg::ZW-30){1'b0}}, gimb_pkg::atan_val(IDX)});

    logic signed [gimb_pkg::XW-1:0] w_xs, w_ys;
    gimb_pkg::t_crd n_d;

    assign w_xs = i_d.x >>> IDX;
    assign w_ys = i_d.y >>> IDX;

    always_comb begin
        n_d = i_d;
        if (!i_d.z[gimb_pkg::ZW-1]) begin
            n_d.x = i_d.x - w_ys;
            n_d.y = i_d.y + w_xs;
            n_d.z = i_d.z - ATAN;
        end else begin
            n_d.x = i_d.x + w_ys;
            n_d.y = i_d.y - w_xs;
            n_d.z = i_d.z + ATAN;
        end
    end

    always_ff @(posedge i_clk) begin
        o_d <= n_d;
    end
endmodule
`default_nettype wire

### src/gimb_matmul.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gimb_matmul
// 3x3 matrix product with rounding, products then sums, two stages.
// ---------------------------------------------------------------------------
module gimb_matmul (
    input  wire logic                i_clk,
    input  wire gimb_pkg::t_mat      i_a,
    input  wire gimb_pkg::t_mat      i_b,
    input  wire gimb_pkg::t_trig_vec i_trig,
    output gimb_pkg::t_mat           o_m,
    output gimb_pkg::t_trig_vec      o_trig
);
    logic signed [67:0] r_p [3][3][3];
    gimb_pkg::t_trig_vec r_trig;
    logic signed [69:0] w_sum [3][3];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                for (int k = 0; k < 3; k++)
                    r_p[i][j][k] <= $signed(i_a[i][k]) * $signed(i_b[k][j]);
        r_trig <= i_trig;
    end

    always_comb begin
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                w_sum[i][j] = 70'(r_p[i][j][0]) + 70'(r_p[i][j][1])
                            + 70'(r_p[i][j][2]) + (70'sd1 <<< 29);
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                o_m[i][j] <= w_sum[i][j][30 +: gimb_pkg::WW];
        o_trig <= r_trig;
    end
endmodule
`default_nettype wire

### src/gimb_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gimb_props
// Port-level checks on the rotation matrix core, bound to the top level.
// ---------------------------------------------------------------------------
module gimb_props #(
    parameter int COEF_FRAC_BITS = gimb_pkg::COEF_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES  = gimb_pkg::CORDIC_STAGES_DEF
) (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           start,
    input wire logic           busy,
    input wire logic           o_valid,
    input wire gimb_pkg::t_out o_out
);
    localparam int LAT = CORDIC_STAGES + 12;
    localparam logic signed [31:0] LIM = 32'sd1 <<< COEF_FRAC_BITS;

    a_never_busy: assert property (@(posedge i_clk) !busy)
        else $error("core reported busy");

    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid)
        else $error("transaction result missing at fixed latency");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($signed(o_out.m00) <= LIM && $signed(o_out.m00) >= -LIM
                  && $signed(o_out.m11) <= LIM && $signed(o_out.m11) >= -LIM
                  && $signed(o_out.m22) <= LIM && $signed(o_out.m22) >= -LIM))
        else $error("matrix entry out of range");
endmodule

bind gimbal_euler_to_rotation_matrix_core gimb_props #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS),
    .CORDIC_STAGES  (CORDIC_STAGES)
) u_gimb_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid),
    .o_out   (o_out)
);
`default_nettype wire
